FILE: rtl/two_neighbour_spring_force_unit_assert.svh
// Assertion macros for the spring force unit RTL, used by tnsf_queue.
`ifndef TWO_NEIGHBOUR_SPRING_FORCE_UNIT_ASSERT_SVH
`define TWO_NEIGHBOUR_SPRING_FORCE_UNIT_ASSERT_SVH

// Clocked check, masked while reset is high.
`define TNSF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define TNSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tnsf_pkg.sv
// ----------------------------------------------------------------------------
// tnsf_pkg
// Shared widths, register codes and control types for the spring force unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tnsf_pkg;

  localparam int STIFF_W    = 16;
  localparam int REST_W     = 23;
  localparam int FORCE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;
  localparam int Q_DEPTH    = 4;

  localparam logic [STIFF_W-1:0] STIFF_RESET = 16'd256;
  localparam logic [REST_W-1:0]  REST_RESET  = 23'd25600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STIFFNESS   = 2'd0,
    CFG_REST_LENGTH = 2'd1
  } cfg_reg_t;

  // Queue status seen by the front (room) and the back (data).
  typedef struct packed {
    logic can_push;
    logic has_data;
  } q_stat_t;

endpackage

FILE: rtl/tnsf_if.sv
// ----------------------------------------------------------------------------
// tnsf_if
// Valid/ready channels: particle items, force results, register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tnsf_item_if #(parameter int POS_WIDTH = 24);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] self_x;
  logic signed [POS_WIDTH-1:0] self_y;
  logic signed [POS_WIDTH-1:0] left_x;
  logic signed [POS_WIDTH-1:0] left_y;
  logic signed [POS_WIDTH-1:0] right_x;
  logic signed [POS_WIDTH-1:0] right_y;
  logic signed [31:0]          force_in_x;
  logic signed [31:0]          force_in_y;

  modport source (output valid, self_x, self_y, left_x, left_y, right_x, right_y,
                  force_in_x, force_in_y, input ready);
  modport sink   (input valid, self_x, self_y, left_x, left_y, right_x, right_y,
                  force_in_x, force_in_y, output ready);
endinterface

interface tnsf_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_out_x;
  logic signed [31:0] force_out_y;

  modport source (output valid, force_out_x, force_out_y, input ready);
  modport sink   (input valid, force_out_x, force_out_y, output ready);
endinterface

interface tnsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [22:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/two_neighbour_spring_force_unit.sv
// ----------------------------------------------------------------------------
// two_neighbour_spring_force_unit
// Adds Hooke spring forces from both ring neighbours to a particle's force.
// ----------------------------------------------------------------------------
//  port    | dir  | beat
//  item    | in   | self, left, right positions and running force
//  result  | out  | force with both springs added, saturated
//  cfg     | in   | register write: index 0 stiffness, 1 rest length
//
//  One item per cycle while result is ready; every stage of the back
//  pipeline advances together. An accepted item passes the front register,
//  the queue, 8 back registers, (POS_WIDTH+1) square-root stages and
//  (POS_WIDTH+10) divider stages (32 below POS_WIDTH 22). Reset restores
//  stiffness 1.0 and rest length 100.0 and empties the pipeline. A stalled
//  result holds the back; the queue lets the front keep taking beats until it
//  fills. cfg is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_neighbour_spring_force_unit import tnsf_pkg::*; #(
  parameter int POS_WIDTH = 24
) (
  input  logic          clk,
  input  logic          rst,
  tnsf_item_if.sink     item,
  tnsf_result_if.source result,
  tnsf_cfg_if.sink      cfg
);

  localparam int QWD = 4 * (POS_WIDTH + 1) + 2 * FORCE_W;

  logic [STIFF_W-1:0] stiffness;
  logic [REST_W-1:0]  rest_length;
  logic               push;
  logic               pop;
  logic [QWD-1:0]     qin;
  logic [QWD-1:0]     qout;
  q_stat_t            stat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness   <= STIFF_RESET;
      rest_length <= REST_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_STIFFNESS) begin
        stiffness <= cfg.data[STIFF_W-1:0];
      end else if (cfg.index == CFG_REST_LENGTH) begin
        rest_length <= cfg.data[REST_W-1:0];
      end
    end
  end

  tnsf_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .stat (stat),
    .push (push),
    .data (qin)
  );

  tnsf_queue #(.WIDTH(QWD)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (qin),
    .pop  (pop),
    .dout (qout),
    .stat (stat)
  );

  tnsf_back #(.POS_WIDTH(POS_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .stat        (stat),
    .pop         (pop),
    .qdata       (qout),
    .stiffness   (stiffness),
    .rest_length (rest_length),
    .result      (result)
  );

endmodule

FILE: rtl/tnsf_queue.sv
// ----------------------------------------------------------------------------
// tnsf_queue
// Small FIFO between the front and back parts of the force unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_neighbour_spring_force_unit_assert.svh"

module tnsf_queue import tnsf_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output q_stat_t          stat
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] mem [Q_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign dout          = mem[rd_ptr];
  assign stat.can_push = (count != CW'(Q_DEPTH));
  assign stat.has_data = (count != '0);

  `TNSF_ASSERT(a_count_bound, clk, rst, count <= CW'(Q_DEPTH), "queue count above depth")
  `TNSF_ASSERT(a_no_push_full, clk, rst, push |-> count != CW'(Q_DEPTH), "push into full queue")
  `TNSF_ASSERT(a_no_pop_empty, clk, rst, pop |-> count != '0, "pop from empty queue")
  `TNSF_ASSERT(a_pop_drains, clk, rst, (pop && !push) |=> count == $past(count) - 1'b1, "pop lost")

endmodule

FILE: rtl/tnsf_front.sv
// ----------------------------------------------------------------------------
// tnsf_front
// Takes particle items, forms neighbour offsets and hands them to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tnsf_front import tnsf_pkg::*; #(
  parameter int POS_WIDTH = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  tnsf_item_if.sink                             item,
  input  q_stat_t                               stat,
  output logic                                  push,
  output logic [4*(POS_WIDTH+1)+2*FORCE_W-1:0]  data
);

  localparam int DW = POS_WIDTH + 1;

  typedef struct packed {
    logic signed [DW-1:0]      lx;
    logic signed [DW-1:0]      ly;
    logic signed [DW-1:0]      rx;
    logic signed [DW-1:0]      ry;
    logic signed [FORCE_W-1:0] fx;
    logic signed [FORCE_W-1:0] fy;
  } geom_t;

  logic  fv;
  geom_t fd;
  geom_t nxt;

  always_comb begin
    nxt.lx = {item.left_x[POS_WIDTH-1], item.left_x} - {item.self_x[POS_WIDTH-1], item.self_x};
    nxt.ly = {item.left_y[POS_WIDTH-1], item.left_y} - {item.self_y[POS_WIDTH-1], item.self_y};
    nxt.rx = {item.right_x[POS_WIDTH-1], item.right_x} - {item.self_x[POS_WIDTH-1], item.self_x};
    nxt.ry = {item.right_y[POS_WIDTH-1], item.right_y} - {item.self_y[POS_WIDTH-1], item.self_y};
    nxt.fx = item.force_in_x;
    nxt.fy = item.force_in_y;
  end

  assign item.ready = !fv || stat.can_push;
  assign push       = fv && stat.can_push;
  assign data       = fd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (item.ready) begin
      fv <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      fd <= nxt;
    end
  end

endmodule

FILE: rtl/tnsf_back.sv
// ----------------------------------------------------------------------------
// tnsf_back
// Spring force pipeline: distance, force magnitude, projection, sum, clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tnsf_back import tnsf_pkg::*; #(
  parameter int POS_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  q_stat_t                              stat,
  output logic                                 pop,
  input  logic [4*(POS_WIDTH+1)+2*FORCE_W-1:0] qdata,
  input  logic [STIFF_W-1:0]                   stiffness,
  input  logic [REST_W-1:0]                    rest_length,
  tnsf_result_if.source                        result
);

  localparam int DW  = POS_WIDTH + 1;
  localparam int LW  = POS_WIDTH + 1;
  localparam int SQW = 2 * LW;
  localparam int RW  = LW + 3;
  localparam int EW  = ((LW > REST_W) ? LW : REST_W) + 1;
  localparam int FW  = EW + STIFF_W + 1;
  localparam int FMW = EW + 8;
  localparam int FLO = (FMW + 1) / 2;
  localparam int FHI = FMW - FLO;
  localparam int NW  = FMW + DW;
  localparam int QW  = FMW;
  localparam int TW  = FMW + 2;
  localparam int SW  = ((TW > FORCE_W) ? TW : FORCE_W) + 2;

  typedef struct packed {
    logic signed [DW-1:0]      lx;
    logic signed [DW-1:0]      ly;
    logic signed [DW-1:0]      rx;
    logic signed [DW-1:0]      ry;
    logic signed [FORCE_W-1:0] fx;
    logic signed [FORCE_W-1:0] fy;
  } geom_t;

  function automatic logic [DW-1:0] mag_d(input logic [DW-1:0] v);
    mag_d = v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  logic en;
  logic out_v;

  assign en  = !out_v || result.ready;
  assign pop = stat.has_data && en;

  // squares of the offsets, order lx ly rx ry
  geom_t          in_g;
  logic [DW-1:0]  in_m [4];
  logic           s1_v;
  geom_t          s1_g;
  logic [SQW-1:0] s1_sq [4];

  always_comb begin
    in_g    = geom_t'(qdata);
    in_m[0] = mag_d(in_g.lx);
    in_m[1] = mag_d(in_g.ly);
    in_m[2] = mag_d(in_g.rx);
    in_m[3] = mag_d(in_g.ry);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_g <= in_g;
      for (int t = 0; t < 4; t++) begin
        s1_sq[t] <= in_m[t] * in_m[t];
      end
    end
  end

  // square root, one result bit per stage
  logic           sr_v    [LW+1];
  geom_t          sr_g    [LW+1];
  logic [SQW-1:0] sr_rad  [LW+1][2];
  logic [LW-1:0]  sr_root [LW+1][2];
  logic [RW-1:0]  sr_rem  [LW+1][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sr_v[0] <= 1'b0;
    end else if (en) begin
      sr_v[0] <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr_g[0] <= s1_g;
      for (int n = 0; n < 2; n++) begin
        sr_rad[0][n]  <= s1_sq[2*n] + s1_sq[2*n+1];
        sr_root[0][n] <= '0;
        sr_rem[0][n]  <= '0;
      end
    end
  end

  for (genvar k = 1; k <= LW; k++) begin : g_sqrt
    logic [RW-1:0] sh [2];
    logic [RW-1:0] tr [2];
    logic          ge [2];

    always_comb begin
      for (int n = 0; n < 2; n++) begin
        sh[n] = {sr_rem[k-1][n][RW-3:0], sr_rad[k-1][n][SQW-1 -: 2]};
        tr[n] = RW'({sr_root[k-1][n], 2'b01});
        ge[n] = (sh[n] >= tr[n]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sr_v[k] <= 1'b0;
      end else if (en) begin
        sr_v[k] <= sr_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_g[k] <= sr_g[k-1];
        for (int n = 0; n < 2; n++) begin
          sr_rad[k][n]  <= {sr_rad[k-1][n][SQW-3:0], 2'b00};
          sr_root[k][n] <= {sr_root[k-1][n][LW-2:0], ge[n]};
          sr_rem[k][n]  <= ge[n] ? (sh[n] - tr[n]) : sh[n];
        end
      end
    end
  end

  // spring force stiffness * (len - rest), Q.16
  logic                 f_v;
  geom_t                f_g;
  logic [LW-1:0]        f_len [2];
  logic signed [FW-1:0] f_big [2];
  logic signed [EW-1:0] ediff [2];

  always_comb begin
    for (int n = 0; n < 2; n++) begin
      ediff[n] = $signed({{(EW-LW){1'b0}}, sr_root[LW][n]})
               - $signed({{(EW-REST_W){1'b0}}, rest_length});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= sr_v[LW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_g <= sr_g[LW];
      for (int n = 0; n < 2; n++) begin
        f_len[n] <= sr_root[LW][n];
        f_big[n] <= $signed({1'b0, stiffness}) * ediff[n];
      end
    end
  end

  // round to Q.8, kept as magnitude and sign
  logic           m_v;
  geom_t          m_g;
  logic [LW-1:0]  m_len  [2];
  logic [FMW-1:0] m_fm   [2];
  logic           m_fneg [2];
  logic [FW-1:0]  fabs   [2];
  logic [FW-1:0]  frnd   [2];

  always_comb begin
    for (int n = 0; n < 2; n++) begin
      fabs[n] = f_big[n][FW-1] ? (~f_big[n] + 1'b1) : f_big[n];
      frnd[n] = fabs[n] + FW'(128);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_g <= f_g;
      for (int n = 0; n < 2; n++) begin
        m_len[n]  <= f_len[n];
        m_fm[n]   <= frnd[n][FMW+7:8];
        m_fneg[n] <= f_big[n][FW-1];
      end
    end
  end

  // f * d in two partial products per term
  logic                      p_v;
  logic signed [FORCE_W-1:0] p_fx;
  logic signed [FORCE_W-1:0] p_fy;
  logic [LW-1:0]             p_len [2];
  logic [FLO+DW-1:0]         p_lo  [4];
  logic [FHI+DW-1:0]         p_hi  [4];
  logic                      p_neg [4];
  logic [DW-1:0]             m_d   [4];

  always_comb begin
    m_d[0] = m_g.lx;
    m_d[1] = m_g.ly;
    m_d[2] = m_g.rx;
    m_d[3] = m_g.ry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_fx <= m_g.fx;
      p_fy <= m_g.fy;
      for (int n = 0; n < 2; n++) begin
        p_len[n] <= m_len[n];
      end
      for (int t = 0; t < 4; t++) begin
        p_lo[t]  <= m_fm[t/2][FLO-1:0] * mag_d(m_d[t]);
        p_hi[t]  <= m_fm[t/2][FMW-1:FLO] * mag_d(m_d[t]);
        p_neg[t] <= m_fneg[t/2] ^ m_d[t][DW-1];
      end
    end
  end

  // division by len, one quotient bit per stage
  logic                      dv_v   [QW+1];
  logic signed [FORCE_W-1:0] dv_fx  [QW+1];
  logic signed [FORCE_W-1:0] dv_fy  [QW+1];
  logic [LW-1:0]             dv_len [QW+1][2];
  logic [LW-1:0]             dv_rem [QW+1][4];
  logic [QW-1:0]             dv_qn  [QW+1][4];
  logic                      dv_neg [QW+1][4];
  logic [NW-1:0]             num    [4];

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      num[t] = NW'(p_lo[t]) + (NW'(p_hi[t]) << FLO);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_fx[0] <= p_fx;
      dv_fy[0] <= p_fy;
      for (int n = 0; n < 2; n++) begin
        dv_len[0][n] <= p_len[n];
      end
      for (int t = 0; t < 4; t++) begin
        // top part is already below len since the quotient fits QW bits
        dv_rem[0][t] <= num[t][NW-1:QW];
        dv_qn[0][t]  <= num[t][QW-1:0];
        dv_neg[0][t] <= p_neg[t];
      end
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [LW:0] sh [4];
    logic [LW:0] dl [4];
    logic        ge [4];

    always_comb begin
      for (int t = 0; t < 4; t++) begin
        sh[t] = {dv_rem[k-1][t], dv_qn[k-1][t][QW-1]};
        dl[t] = {1'b0, dv_len[k-1][t/2]};
        ge[t] = (sh[t] >= dl[t]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else if (en) begin
        dv_v[k] <= dv_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_fx[k] <= dv_fx[k-1];
        dv_fy[k] <= dv_fy[k-1];
        for (int n = 0; n < 2; n++) begin
          dv_len[k][n] <= dv_len[k-1][n];
        end
        for (int t = 0; t < 4; t++) begin
          dv_rem[k][t] <= ge[t] ? LW'(sh[t] - dl[t]) : sh[t][LW-1:0];
          dv_qn[k][t]  <= {dv_qn[k-1][t][QW-2:0], ge[t]};
          dv_neg[k][t] <= dv_neg[k-1][t];
        end
      end
    end
  end

  // round half away from zero, apply sign, drop coincident neighbours
  logic                      r_v;
  logic signed [FORCE_W-1:0] r_fx;
  logic signed [FORCE_W-1:0] r_fy;
  logic signed [TW-1:0]      r_term [4];
  logic [QW:0]               qmag   [4];
  logic                      up     [4];

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      up[t]   = ({dv_rem[QW][t], 1'b0} >= {1'b0, dv_len[QW][t/2]});
      qmag[t] = (QW+1)'(dv_qn[QW][t]) + (QW+1)'(up[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (en) begin
      r_v <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_fx <= dv_fx[QW];
      r_fy <= dv_fy[QW];
      for (int t = 0; t < 4; t++) begin
        if (dv_len[QW][t/2] == '0) begin
          r_term[t] <= '0;
        end else if (dv_neg[QW][t]) begin
          r_term[t] <= -$signed({1'b0, qmag[t]});
        end else begin
          r_term[t] <= $signed({1'b0, qmag[t]});
        end
      end
    end
  end

  // sum and clamp to the force range
  logic signed [SW-1:0]      sum_x;
  logic signed [SW-1:0]      sum_y;
  logic signed [FORCE_W-1:0] sat_x;
  logic signed [FORCE_W-1:0] sat_y;

  function automatic logic [FORCE_W-1:0] clamp(input logic [SW-1:0] v);
    logic [SW-FORCE_W:0] top;
    top = v[SW-1:FORCE_W-1];
    if ((&top) || !(|top)) begin
      clamp = v[FORCE_W-1:0];
    end else if (v[SW-1]) begin
      clamp = {1'b1, {(FORCE_W-1){1'b0}}};
    end else begin
      clamp = {1'b0, {(FORCE_W-1){1'b1}}};
    end
  endfunction

  always_comb begin
    sum_x = SW'(r_fx) + SW'(r_term[0]) + SW'(r_term[2]);
    sum_y = SW'(r_fy) + SW'(r_term[1]) + SW'(r_term[3]);
    sat_x = clamp(sum_x);
    sat_y = clamp(sum_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.force_out_x <= sat_x;
      result.force_out_y <= sat_y;
    end
  end

  assign result.valid = out_v;

endmodule

FILE: tb/sv/tb_two_neighbour_spring_force_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_neighbour_spring_force_unit
// Drives particle beats through the spring force unit and checks each force
// result against a bit-exact predictor. A directed table covers the position
// and force extremes, coincident neighbours, springs at rest length and
// saturation; ignored register indexes are tested next. Random beats follow
// under several register settings and idling modes on both sides of the unit.
// ----------------------------------------------------------------------------

module tb_two_neighbour_spring_force_unit;
  import tnsf_pkg::*;

  localparam int PW           = 24;
  localparam int LATENCY      = 1 + 8 + (PW + 1) + (PW + 10);
  localparam int WATCHDOG_MAX = 20000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam logic signed [31:0] F_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] F_MIN = 32'sh80000000;
  localparam logic signed [PW-1:0] P_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] P_MIN = {1'b1, {(PW-1){1'b0}}};

  typedef struct {
    logic signed [PW-1:0] sx, sy, lx, ly, rx, ry;
    logic signed [31:0]   fx, fy;
  } particle_t;

  typedef struct {
    logic signed [31:0] x, y;
  } force_t;

  typedef struct {
    particle_t p;
    bit        known;
    force_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tnsf_item_if #(.POS_WIDTH(PW)) item_ch ();
  tnsf_result_if                 res_ch ();
  tnsf_cfg_if                    cfg_ch ();

  two_neighbour_spring_force_unit #(.POS_WIDTH(PW)) uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (res_ch.source),
    .cfg    (cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [STIFF_W-1:0] mdl_stiff;
  logic [REST_W-1:0]  mdl_rest;
  force_t             force_q[$];
  stim_row_t          table_rows[$];
  int                 errors = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 quiet_cycles = 0;

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned rem, root, trial;
    rem  = 0;
    root = 0;
    for (int p = 31; p >= 0; p--) begin
      rem   = (rem << 2) | ((v >> (2 * p)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // f * d / len, rounded half away from zero
  function automatic longint project(input longint f, input longint d,
                                     input longint unsigned len);
    logic [127:0] prod, q, r;
    longint unsigned mf, md;
    mf   = (f < 0) ? -f : f;
    md   = (d < 0) ? -d : d;
    prod = 128'(mf) * 128'(md);
    q    = prod / 128'(len);
    r    = prod % 128'(len);
    if (2 * r >= 128'(len)) q = q + 1;
    return ((f < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  task automatic spring_pull(input longint dx, input longint dy,
                             output longint tx, output longint ty);
    longint unsigned len, fm;
    longint big_f, f;
    len = floor_root(longint'(dx * dx + dy * dy));
    if (len == 0) begin
      tx = 0;
      ty = 0;
    end else begin
      big_f = longint'(mdl_stiff) * (longint'(len) - longint'(mdl_rest));
      fm    = (((big_f < 0) ? -big_f : big_f) + 128) >> 8;
      f     = (big_f < 0) ? -longint'(fm) : longint'(fm);
      tx    = project(f, dx, len);
      ty    = project(f, dy, len);
    end
  endtask

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return F_MAX;
    if (v < -64'sd2147483648) return F_MIN;
    return v[31:0];
  endfunction

  task automatic predict_force(input particle_t p, output force_t o);
    longint ltx, lty, rtx, rty;
    spring_pull(longint'(p.lx) - longint'(p.sx), longint'(p.ly) - longint'(p.sy), ltx, lty);
    spring_pull(longint'(p.rx) - longint'(p.sx), longint'(p.ry) - longint'(p.sy), rtx, rty);
    o.x = clamp32(longint'(p.fx) + ltx + rtx);
    o.y = clamp32(longint'(p.fy) + lty + rty);
  endtask

  task automatic send_particle(input particle_t p, input bit known, input force_t want);
    force_t o;
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.self_x     <= p.sx;
    item_ch.self_y     <= p.sy;
    item_ch.left_x     <= p.lx;
    item_ch.left_y     <= p.ly;
    item_ch.right_x    <= p.rx;
    item_ch.right_y    <= p.ry;
    item_ch.force_in_x <= p.fx;
    item_ch.force_in_y <= p.fy;
    do @(posedge clk); while (!item_ch.ready);
    if (known) o = want;
    else predict_force(p, o);
    force_q.push_back(o);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (force_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_STIFFNESS) mdl_stiff = val[STIFF_W-1:0];
    else if (idx == CFG_REST_LENGTH) mdl_rest = val[REST_W-1:0];
    // idle with valid low so the next write starts on a later edge
    @(posedge clk);
  endtask

  task automatic add_row(input particle_t p, input bit known, input force_t want);
    stim_row_t r;
    r.p     = p;
    r.known = known;
    r.want  = want;
    table_rows.push_back(r);
  endtask

  function automatic logic signed [PW-1:0] rand_pos();
    return PW'($urandom);
  endfunction

  // Neighbour offset of random scale so lengths land near and far from rest.
  function automatic logic signed [PW-1:0] near(input logic signed [PW-1:0] base);
    int sh;
    logic signed [31:0] off;
    sh  = $urandom_range(18, 4);
    off = $signed($urandom) >>> (31 - sh);
    return base + PW'(off);
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    p.fx = $urandom;
    p.fy = $urandom;
    if ($urandom_range(99) < 20) p.fx = ($urandom_range(1)) ? F_MAX - 32'($urandom_range(4095))
                                                          : F_MIN + 32'($urandom_range(4095));
    if ($urandom_range(99) < 75) begin
      p.sx = rand_pos();
      p.sy = rand_pos();
      p.lx = near(p.sx);
      p.ly = near(p.sy);
      p.rx = near(p.sx);
      p.ry = near(p.sy);
      if ($urandom_range(99) < 8) begin
        p.rx = p.sx;
        p.ry = p.sy;
      end
    end else begin
      p.sx = rand_pos();
      p.sy = rand_pos();
      p.lx = rand_pos();
      p.ly = rand_pos();
      p.rx = rand_pos();
      p.ry = rand_pos();
    end
    return p;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    force_t w;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (force_q.size() == 0) begin
        $error("unexpected result beat x=%0d y=%0d", res_ch.force_out_x, res_ch.force_out_y);
        errors++;
      end else begin
        w = force_q.pop_front();
        if (res_ch.force_out_x !== w.x) begin
          $error("force_out_x expected %0d actual %0d", w.x, res_ch.force_out_x);
          errors++;
        end
        if (res_ch.force_out_y !== w.y) begin
          $error("force_out_y expected %0d actual %0d", w.y, res_ch.force_out_y);
          errors++;
        end
      end
    end
  end

  // Count cycles with no beat on any of the item, result and cfg channels.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("tb_two_neighbour_spring_force_unit: FAIL");
        $finish;
      end
    end
  end

  initial begin
    particle_t p;
    force_t    w, none;
    int        n;

    item_ch.valid      <= 1'b0;
    item_ch.self_x     <= '0;
    item_ch.self_y     <= '0;
    item_ch.left_x     <= '0;
    item_ch.left_y     <= '0;
    item_ch.right_x    <= '0;
    item_ch.right_y    <= '0;
    item_ch.force_in_x <= '0;
    item_ch.force_in_y <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_STIFFNESS;
    cfg_ch.data        <= '0;
    mdl_stiff = STIFF_RESET;
    mdl_rest  = REST_RESET;
    none.x = 0;
    none.y = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // coincident neighbours: force passes through
    p = '{sx: 0, sy: 0, lx: 0, ly: 0, rx: 0, ry: 0, fx: 0, fy: 0};
    add_row(p, 1, none);
    p = '{sx: P_MAX, sy: P_MIN, lx: P_MAX, ly: P_MIN, rx: P_MAX, ry: P_MIN, fx: F_MAX, fy: F_MIN};
    w = '{x: F_MAX, y: F_MIN};
    add_row(p, 1, w);
    p = '{sx: P_MIN, sy: P_MAX, lx: P_MIN, ly: P_MAX, rx: P_MIN, ry: P_MAX, fx: F_MIN, fy: F_MAX};
    w = '{x: F_MIN, y: F_MAX};
    add_row(p, 1, w);
    // both springs exactly at rest length (100.0)
    p = '{sx: 0, sy: 0, lx: 25600, ly: 0, rx: 0, ry: -25600, fx: 12345, fy: -678};
    w = '{x: 12345, y: -678};
    add_row(p, 1, w);
    // stretched, compressed, diagonal
    p = '{sx: 0, sy: 0, lx: 51200, ly: 0, rx: 0, ry: 0, fx: 0, fy: 0};
    add_row(p, 0, none);
    p = '{sx: 1000, sy: -1000, lx: 1000, ly: 2000, rx: 1300, ry: -600, fx: 5, fy: -5};
    add_row(p, 0, none);
    p = '{sx: 0, sy: 0, lx: 768, ly: 1024, rx: -3, ry: 4, fx: 0, fy: 0};
    add_row(p, 0, none);
    // position extremes, far neighbours
    p = '{sx: P_MIN, sy: P_MIN, lx: P_MAX, ly: P_MAX, rx: P_MAX, ry: P_MIN, fx: 0, fy: 0};
    add_row(p, 0, none);
    p = '{sx: P_MAX, sy: P_MAX, lx: P_MIN, ly: P_MIN, rx: P_MIN, ry: P_MAX, fx: -1, fy: 1};
    add_row(p, 0, none);
    // saturation both ways
    p = '{sx: 0, sy: 0, lx: P_MAX, ly: P_MAX, rx: P_MAX, ry: 0, fx: F_MAX, fy: F_MAX};
    add_row(p, 0, none);
    p = '{sx: 0, sy: 0, lx: P_MIN, ly: P_MIN, rx: 0, ry: P_MIN, fx: F_MIN, fy: F_MIN};
    add_row(p, 0, none);
    p = '{sx: 0, sy: 0, lx: 1, ly: 0, rx: 0, ry: 1, fx: F_MIN, fy: F_MAX};
    add_row(p, 0, none);

    foreach (table_rows[i]) send_particle(table_rows[i].p, table_rows[i].known,
                                          table_rows[i].want);
    drain();

    // unused indexes leave both registers alone
    write_reg(CFG_SPARE_2, 23'h7fffff);
    write_reg(CFG_SPARE_3, 23'h000001);
    p = '{sx: 0, sy: 0, lx: 51200, ly: 0, rx: 0, ry: -12800, fx: 0, fy: 0};
    send_particle(p, 0, none);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      send_idle_pct  = (phase % 4 == 1) ? 82 : (phase % 4 == 3) ? 31 : 0;
      recv_stall_pct = (phase % 4 == 2) ? 82 : (phase % 4 == 3) ? 31 : 0;
      case (phase)
        0: begin
          write_reg(CFG_STIFFNESS, 23'd0);
          write_reg(CFG_REST_LENGTH, 23'd0);
        end
        1: begin
          write_reg(CFG_STIFFNESS, 23'hffff);
          write_reg(CFG_REST_LENGTH, 23'h7fffff);
        end
        2: begin
          write_reg(CFG_STIFFNESS, 23'hffff);
          write_reg(CFG_REST_LENGTH, 23'd0);
        end
        3: begin
          write_reg(CFG_STIFFNESS, CFG_DATA_W'(STIFF_RESET));
          write_reg(CFG_REST_LENGTH, CFG_DATA_W'(REST_RESET));
        end
        default: begin
          write_reg(CFG_STIFFNESS, 23'($urandom_range(16'hffff)));
          write_reg(CFG_REST_LENGTH, 23'($urandom) >> $urandom_range(14));
        end
      endcase
      n = 0;
      while (n < 140) begin
        send_particle(rand_particle(), 0, none);
        n++;
        // hold off once until the pipeline runs dry
        if (phase == 5 && n == 70) begin
          item_ch.valid <= 1'b0;
          while (force_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb_two_neighbour_spring_force_unit: PASS");
    end else begin
      $display("tb_two_neighbour_spring_force_unit: FAIL");
    end
    $finish;
  end

endmodule
